// ===== sv/mpcd_pkg.sv =====
package mpcd_pkg;

  localparam logic [7:0] SYNC_CSUM_A = 8'h57;
  localparam logic [7:0] SYNC_CSUM_B = 8'hAB;
  localparam logic [7:0] SYNC_LEN    = 8'h50;
  localparam logic [7:0] PRINT_LO    = 8'h20;
  localparam logic [7:0] PRINT_END   = 8'h7F;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_CR     = 8'h0D;

  localparam int MAX_BIN_PAYLOAD = 32;
  localparam int MAX_LEN_PAYLOAD = 64;
  localparam int MAX_LINE        = 64;

  localparam int STORE_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int FILL_W      = ADDR_W + 1;

  localparam logic [1:0] PROTO_CSUM = 2'd0;
  localparam logic [1:0] PROTO_LEN  = 2'd1;
  localparam logic [1:0] PROTO_TEXT = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_CSUM   = 2'd1;
  localparam logic [1:0] ST_LENGTH = 2'd2;

  localparam logic MODE_DATA      = 1'b0;
  localparam logic MODE_LINE_ERR  = 1'b1;

endpackage

// ===== sv/mpcd_in_if.sv =====
interface mpcd_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] rx_byte;

  modport source (output valid, output mode, output rx_byte, input ready);
  modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

// ===== sv/mpcd_out_if.sv =====
interface mpcd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  protocol;
  logic [1:0]  status;
  logic [7:0]  command;
  logic [15:0] length;
  logic [7:0]  data_byte;
  logic [5:0]  byte_index;
  logic        has_data;
  logic        last;
  logic [31:0] good_count;
  logic [31:0] bad_count;

  modport source (
    output valid, output protocol, output status, output command, output length,
    output data_byte, output byte_index, output has_data, output last,
    output good_count, output bad_count, input ready
  );
  modport sink (
    input valid, input protocol, input status, input command, input length,
    input data_byte, input byte_index, input has_data, input last,
    input good_count, input bad_count, output ready
  );
endinterface

// ===== sv/mpcd_ram.sv =====
module mpcd_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/multi_protocol_command_deframer.sv =====
// Channel  Role    Payload
// din      sink    mode, rx_byte
// dout     source  protocol, status, command, length, data_byte, byte_index,
//                  has_data, last, good_count, bad_count
//
// A received byte is taken whenever din is ready; payload bytes go into a 64-entry payload RAM.
// A completed frame with payload drains one result per byte, each by a RAM read and then an output load,
// so din is blocked from the frame's final byte until the last of those results is loaded.
// Error and empty-frame results load the output register in the accept cycle.
// Synchronous active-high reset clears control state and counters; the RAM is not cleared.
// din stalls while draining or while a result waits in the output register untaken.
module multi_protocol_command_deframer (
  input  logic        clk,
  input  logic        rst,
  mpcd_in_if.sink     din,
  mpcd_out_if.source  dout
);
  import mpcd_pkg::*;

  typedef enum logic [1:0] {PM_IDLE, PM_CSUM, PM_LEN, PM_TEXT} pm_t;
  typedef enum logic [2:0] {CS_SYNC2, CS_CMD, CS_LEN, CS_PAY, CS_SUM} cs_t;
  typedef enum logic [1:0] {LS_CMD, LS_LO, LS_HI, LS_PAY} ls_t;
  typedef enum logic [1:0] {PH_RUN, PH_RD, PH_LOAD} phase_t;

  pm_t    pm;
  cs_t    cs;
  ls_t    ls;
  phase_t phase;

  logic [7:0]        held_command;
  logic [15:0]       held_length;
  logic [FILL_W-1:0] fill;
  logic [7:0]        running_sum;
  logic [31:0]       good_frames;
  logic [31:0]       bad_frames;

  logic [ADDR_W-1:0] drain_idx;
  logic [FILL_W-1:0] drain_n;
  logic [1:0]        drain_proto;
  logic [7:0]        drain_cmd;
  logic [15:0]       drain_len;

  logic        out_valid;
  logic [1:0]  out_protocol;
  logic [1:0]  out_status;
  logic [7:0]  out_command;
  logic [15:0] out_length;
  logic [7:0]  out_data;
  logic [5:0]  out_index;
  logic        out_has;
  logic        out_last;
  logic [31:0] out_good;
  logic [31:0] out_bad;

  logic              acc;
  logic              data_acc;
  logic              out_free;
  logic              printable;
  logic              term;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        rd_data;
  logic [FILL_W-1:0] fill_inc;
  logic [15:0]       len16;
  logic [7:0]        sum_inc;
  logic              drain_last;

  assign out_free  = !out_valid || dout.ready;
  assign din.ready = (phase == PH_RUN) && out_free;
  assign acc       = din.valid && din.ready;
  assign data_acc  = acc && (din.mode == MODE_DATA);
  assign fill_inc  = fill + FILL_W'(1);
  assign len16     = {din.rx_byte, held_length[7:0]};
  assign sum_inc   = running_sum + din.rx_byte;
  assign drain_last = ({1'b0, drain_idx} + FILL_W'(1)) == drain_n;

  always_comb begin
    printable = din.rx_byte inside {[PRINT_LO:PRINT_END - 8'd1]};
    term      = (din.rx_byte == CHAR_LF) || (din.rx_byte == CHAR_CR);
    wr_en     = 1'b0;
    wr_addr   = fill[ADDR_W-1:0];
    case (pm)
      PM_IDLE: begin
        wr_en   = printable && (din.rx_byte != SYNC_CSUM_A) && (din.rx_byte != SYNC_LEN);
        wr_addr = '0;
      end
      PM_CSUM: wr_en = (cs == CS_PAY);
      PM_LEN:  wr_en = (ls == LS_PAY);
      PM_TEXT: wr_en = !term && (fill < FILL_W'(MAX_LINE - 1));
      default: wr_en = 1'b0;
    endcase
    wr_en = wr_en && data_acc;
  end

  mpcd_ram #(
    .DEPTH (STORE_DEPTH),
    .WIDTH (8)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (din.rx_byte),
    .re    (phase == PH_RD),
    .raddr (drain_idx),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pm          <= PM_IDLE;
      cs          <= CS_SYNC2;
      ls          <= LS_CMD;
      phase       <= PH_RUN;
      held_command <= '0;
      held_length <= '0;
      fill        <= '0;
      running_sum <= '0;
      good_frames <= '0;
      bad_frames  <= '0;
      drain_idx   <= '0;
      drain_n     <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (dout.valid && dout.ready) begin
        out_valid <= 1'b0;
      end
      if (acc && din.mode == MODE_LINE_ERR) begin
        pm   <= PM_IDLE;
        fill <= '0;
      end else if (data_acc) begin
        case (pm)
          PM_IDLE: begin
            if (din.rx_byte == SYNC_CSUM_A) begin
              pm          <= PM_CSUM;
              running_sum <= SYNC_CSUM_A;
              cs          <= CS_SYNC2;
            end else if (din.rx_byte == SYNC_LEN) begin
              pm <= PM_LEN;
              ls <= LS_CMD;
            end else if (printable) begin
              pm   <= PM_TEXT;
              fill <= FILL_W'(1);
            end
          end
          PM_CSUM: begin
            case (cs)
              CS_SYNC2: begin
                if (din.rx_byte == SYNC_CSUM_B) begin
                  running_sum <= sum_inc;
                  cs          <= CS_CMD;
                end else if (din.rx_byte == SYNC_CSUM_A) begin
                  running_sum <= SYNC_CSUM_A;
                end else begin
                  pm <= PM_IDLE;
                end
              end
              CS_CMD: begin
                held_command <= din.rx_byte;
                running_sum  <= sum_inc;
                cs           <= CS_LEN;
              end
              CS_LEN: begin
                held_length <= {8'd0, din.rx_byte};
                running_sum <= sum_inc;
                if (din.rx_byte > 8'(MAX_BIN_PAYLOAD)) begin
                  pm           <= PM_IDLE;
                  bad_frames   <= bad_frames + 32'd1;
                  out_valid    <= 1'b1;
                  out_protocol <= PROTO_CSUM;
                  out_status   <= ST_LENGTH;
                  out_command  <= held_command;
                  out_length   <= {8'd0, din.rx_byte};
                  out_data     <= '0;
                  out_index    <= '0;
                  out_has      <= 1'b0;
                  out_last     <= 1'b1;
                  out_good     <= good_frames;
                  out_bad      <= bad_frames + 32'd1;
                end else begin
                  fill <= '0;
                  cs   <= (din.rx_byte == 8'd0) ? CS_SUM : CS_PAY;
                end
              end
              CS_PAY: begin
                fill        <= fill_inc;
                running_sum <= sum_inc;
                if ({{(16-FILL_W){1'b0}}, fill_inc} >= held_length) begin
                  cs <= CS_SUM;
                end
              end
              default: begin
                pm <= PM_IDLE;
                if (running_sum != din.rx_byte) begin
                  bad_frames   <= bad_frames + 32'd1;
                  out_valid    <= 1'b1;
                  out_protocol <= PROTO_CSUM;
                  out_status   <= ST_CSUM;
                  out_command  <= held_command;
                  out_length   <= held_length;
                  out_data     <= '0;
                  out_index    <= '0;
                  out_has      <= 1'b0;
                  out_last     <= 1'b1;
                  out_good     <= good_frames;
                  out_bad      <= bad_frames + 32'd1;
                end else begin
                  good_frames <= good_frames + 32'd1;
                  if (held_length == 16'd0) begin
                    out_valid    <= 1'b1;
                    out_protocol <= PROTO_CSUM;
                    out_status   <= ST_OK;
                    out_command  <= held_command;
                    out_length   <= held_length;
                    out_data     <= '0;
                    out_index    <= '0;
                    out_has      <= 1'b0;
                    out_last     <= 1'b1;
                    out_good     <= good_frames + 32'd1;
                    out_bad      <= bad_frames;
                  end else begin
                    phase       <= PH_RD;
                    drain_idx   <= '0;
                    drain_n     <= held_length[FILL_W-1:0];
                    drain_proto <= PROTO_CSUM;
                    drain_cmd   <= held_command;
                    drain_len   <= held_length;
                  end
                end
              end
            endcase
          end
          PM_LEN: begin
            case (ls)
              LS_CMD: begin
                held_command <= din.rx_byte;
                ls           <= LS_LO;
              end
              LS_LO: begin
                held_length <= {8'd0, din.rx_byte};
                ls          <= LS_HI;
              end
              LS_HI: begin
                held_length <= len16;
                if (len16 > 16'(MAX_LEN_PAYLOAD)) begin
                  pm           <= PM_IDLE;
                  bad_frames   <= bad_frames + 32'd1;
                  out_valid    <= 1'b1;
                  out_protocol <= PROTO_LEN;
                  out_status   <= ST_LENGTH;
                  out_command  <= held_command;
                  out_length   <= len16;
                  out_data     <= '0;
                  out_index    <= '0;
                  out_has      <= 1'b0;
                  out_last     <= 1'b1;
                  out_good     <= good_frames;
                  out_bad      <= bad_frames + 32'd1;
                end else if (len16 == 16'd0) begin
                  pm           <= PM_IDLE;
                  good_frames  <= good_frames + 32'd1;
                  out_valid    <= 1'b1;
                  out_protocol <= PROTO_LEN;
                  out_status   <= ST_OK;
                  out_command  <= held_command;
                  out_length   <= '0;
                  out_data     <= '0;
                  out_index    <= '0;
                  out_has      <= 1'b0;
                  out_last     <= 1'b1;
                  out_good     <= good_frames + 32'd1;
                  out_bad      <= bad_frames;
                end else begin
                  fill <= '0;
                  ls   <= LS_PAY;
                end
              end
              default: begin
                fill <= fill_inc;
                if ({{(16-FILL_W){1'b0}}, fill_inc} >= held_length) begin
                  pm          <= PM_IDLE;
                  good_frames <= good_frames + 32'd1;
                  phase       <= PH_RD;
                  drain_idx   <= '0;
                  drain_n     <= held_length[FILL_W-1:0];
                  drain_proto <= PROTO_LEN;
                  drain_cmd   <= held_command;
                  drain_len   <= held_length;
                end
              end
            endcase
          end
          default: begin
            if (term) begin
              pm   <= PM_IDLE;
              fill <= '0;
              if (fill != '0) begin
                phase       <= PH_RD;
                drain_idx   <= '0;
                drain_n     <= fill;
                drain_proto <= PROTO_TEXT;
                drain_cmd   <= '0;
                drain_len   <= {{(16-FILL_W){1'b0}}, fill};
              end
            end else if (fill < FILL_W'(MAX_LINE - 1)) begin
              fill <= fill_inc;
            end else begin
              fill <= '0;
              pm   <= PM_IDLE;
            end
          end
        endcase
      end

      case (phase)
        PH_RD: phase <= PH_LOAD;
        PH_LOAD: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            out_protocol <= drain_proto;
            out_status   <= ST_OK;
            out_command  <= drain_cmd;
            out_length   <= drain_len;
            out_data     <= rd_data;
            out_index    <= drain_idx;
            out_has      <= 1'b1;
            out_last     <= drain_last;
            out_good     <= good_frames;
            out_bad      <= bad_frames;
            if (drain_last) begin
              phase <= PH_RUN;
            end else begin
              drain_idx <= drain_idx + ADDR_W'(1);
              phase     <= PH_RD;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign dout.valid      = out_valid;
  assign dout.protocol   = out_protocol;
  assign dout.status     = out_status;
  assign dout.command    = out_command;
  assign dout.length     = out_length;
  assign dout.data_byte  = out_data;
  assign dout.byte_index = out_index;
  assign dout.has_data   = out_has;
  assign dout.last       = out_last;
  assign dout.good_count = out_good;
  assign dout.bad_count  = out_bad;

  a_rd_then_load: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_RD) |=> (phase == PH_LOAD))
    else $error("drain read not followed by load");

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_RUN) |-> ({1'b0, drain_idx} < drain_n))
    else $error("drain index beyond frame length");

  a_no_write_drain: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_RUN) |-> !wr_en)
    else $error("payload store written while draining");

  a_final_load: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_LOAD && out_free && drain_last) |=>
      (phase == PH_RUN && out_valid && out_last && out_has))
    else $error("final payload result not marked last");

  a_nodata_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_has) |-> out_last)
    else $error("result without data not marked last");

endmodule
